@@ design/vnb_pkg.sv @@
// ----------------------------------------------------------------------------
// vnb_pkg
// Shared types and constants for the vertical normalized blur.
// ----------------------------------------------------------------------------
package vnb_pkg;

  localparam int MAX_RADIUS_DEF   = 32;
  localparam int CHANNEL_BITS_DEF = 24;

  localparam int ROW_W   = 16;  // row counter
  localparam int RAD_W   = 6;   // radius register
  localparam int STR_W   = 6;   // tap stride register
  localparam int SLOT_W  = 7;   // window slot / tap index, covers depth up to 127
  localparam int WGT_W   = 16;  // Q0.16 weight
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W  = 2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic OP_LOAD_WEIGHT = 1'b0;
  localparam logic OP_PUSH_PIXEL  = 1'b1;

  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_STRIDE = 1'b1;

  // one output row to compute
  typedef struct packed {
    logic [ROW_W-1:0]  y;
    logic [ROW_W-1:0]  bottom;
    logic [SLOT_W-1:0] bottom_slot;
    logic [RAD_W-1:0]  r;
    logic [STR_W-1:0]  s;
    logic              last;
  } job_t;

  typedef struct packed {
    logic              pix_we;
    logic [SLOT_W-1:0] pix_slot;
    logic              wgt_we;
    logic [SLOT_W-1:0] wgt_idx;
    logic [WGT_W-1:0]  wgt_val;
  } mem_wr_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

@@ design/vnb_queue.sv @@
// ----------------------------------------------------------------------------
// vnb_queue
// Small job FIFO between the front and the back.
// ----------------------------------------------------------------------------
module vnb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vnb_pkg::job_t push_job,
  input  logic          pop,
  output vnb_pkg::job_t pop_job,
  output vnb_pkg::q_stat_t stat
);
  import vnb_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_job    = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/vnb_front.sv @@
// ----------------------------------------------------------------------------
// vnb_front
// Accepts words, stores weights and pixels, and queues the rows to emit.
// ----------------------------------------------------------------------------
module vnb_front #(
  parameter int MAX_RADIUS   = vnb_pkg::MAX_RADIUS_DEF,
  parameter int CHANNEL_BITS = vnb_pkg::CHANNEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic [vnb_pkg::SLOT_W-1:0]    weight_index,
  input  logic [vnb_pkg::WGT_W-1:0]     weight_value,
  input  logic [4*CHANNEL_BITS-1:0]     pixel,
  input  logic                          column_end,
  input  logic [vnb_pkg::RAD_W-1:0]     radius,
  input  logic [vnb_pkg::STR_W-1:0]     tap_stride,
  input  vnb_pkg::q_stat_t              q_stat,
  input  logic                          back_idle,
  output logic                          job_push,
  output vnb_pkg::job_t                 job,
  output vnb_pkg::mem_wr_t              wr,
  output logic [4*CHANNEL_BITS-1:0]     wr_pixel
);
  import vnb_pkg::*;

  localparam int DEPTH = 2 * MAX_RADIUS + 1;

  typedef enum logic [1:0] {
    F_IDLE  = 2'b01,
    F_FLUSH = 2'b10
  } fstate_t;

  fstate_t           state;
  logic [ROW_W-1:0]  row_count;
  logic [SLOT_W-1:0] cur_slot;
  job_t              flush_job;
  logic              accept;
  logic [RAD_W-1:0]  r_eff;
  logic [STR_W-1:0]  s_eff;
  logic              push_px;

  assign in_ready = (state == F_IDLE) && q_stat.empty && back_idle;
  assign accept   = in_valid && in_ready;
  assign push_px  = accept && (opcode == OP_PUSH_PIXEL);

  assign r_eff = (radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius;
  assign s_eff = (tap_stride == '0) ? STR_W'(1) : tap_stride;

  always_comb begin
    wr.pix_we   = push_px;
    wr.pix_slot = cur_slot;
    wr.wgt_we   = accept && (opcode == OP_LOAD_WEIGHT) &&
                  (weight_index < SLOT_W'(DEPTH));
    wr.wgt_idx  = weight_index;
    wr.wgt_val  = weight_value;
    wr_pixel    = pixel;
  end

  always_comb begin
    job_push        = 1'b0;
    job.y           = row_count - ROW_W'(r_eff);
    job.bottom      = row_count;
    job.bottom_slot = cur_slot;
    job.r           = r_eff;
    job.s           = s_eff;
    job.last        = 1'b0;
    unique case (state)
      F_IDLE: begin
        job_push = push_px && !column_end && (row_count >= ROW_W'(r_eff));
      end
      F_FLUSH: begin
        job      = flush_job;
        job.last = (flush_job.y == flush_job.bottom);
        job_push = !q_stat.full;
      end
      default: job_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      row_count <= '0;
      cur_slot  <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (push_px) begin
            if (column_end) begin
              state     <= F_FLUSH;
              row_count <= '0;
              cur_slot  <= '0;
            end else begin
              row_count <= row_count + 1'b1;
              if (row_count == '1 || cur_slot == SLOT_W'(DEPTH - 1)) begin
                cur_slot <= '0;
              end else begin
                cur_slot <= cur_slot + 1'b1;
              end
            end
          end
        end
        F_FLUSH: begin
          if (!q_stat.full && flush_job.y == flush_job.bottom) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && push_px && column_end) begin
      flush_job.y           <= (row_count >= ROW_W'(r_eff)) ?
                               row_count - ROW_W'(r_eff) : '0;
      flush_job.bottom      <= row_count;
      flush_job.bottom_slot <= cur_slot;
      flush_job.r           <= r_eff;
      flush_job.s           <= s_eff;
      flush_job.last        <= 1'b0;
    end else if (state == F_FLUSH && !q_stat.full) begin
      flush_job.y <= flush_job.y + 1'b1;
    end
  end

endmodule

@@ design/vnb_back.sv @@
// ----------------------------------------------------------------------------
// vnb_back
// Walks the taps of one row serially, then divides each channel by the
// weight sum with a shared restoring divider.
// ----------------------------------------------------------------------------
module vnb_back #(
  parameter int MAX_RADIUS   = vnb_pkg::MAX_RADIUS_DEF,
  parameter int CHANNEL_BITS = vnb_pkg::CHANNEL_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  vnb_pkg::mem_wr_t          wr,
  input  logic [4*CHANNEL_BITS-1:0] wr_pixel,
  input  vnb_pkg::q_stat_t          q_stat,
  input  vnb_pkg::job_t             q_job,
  output logic                      q_pop,
  output logic                      idle,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [4*CHANNEL_BITS-1:0] out_pixel,
  output logic                      out_zero,
  output logic                      out_last
);
  import vnb_pkg::*;

  localparam int DEPTH = 2 * MAX_RADIUS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int WS_W  = WGT_W + SLOT_W;
  localparam int ACC_W = CHANNEL_BITS + WS_W;
  localparam int PRD_W = CHANNEL_BITS + WGT_W + 1;
  localparam int CNT_W = $clog2(ACC_W);

  typedef enum logic [9:0] {
    B_IDLE  = 10'b0000000001,
    B_SETUP = 10'b0000000010,
    B_RD    = 10'b0000000100,
    B_MUL   = 10'b0000001000,
    B_ACC   = 10'b0000010000,
    B_DINIT = 10'b0000100000,
    B_DLOAD = 10'b0001000000,
    B_DSTEP = 10'b0010000000,
    B_DFIN  = 10'b0100000000,
    B_OUT   = 10'b1000000000
  } bstate_t;

  logic [WGT_W-1:0]          wmem [DEPTH];
  logic [4*CHANNEL_BITS-1:0] pmem [DEPTH];

  bstate_t                   state;
  job_t                      jb;
  logic [ROW_W:0]            ny;
  logic [ROW_W:0]            hi;
  logic [WGT_W-1:0]          w_q;
  logic [4*CHANNEL_BITS-1:0] p_q;
  logic signed [PRD_W-1:0]   prod [4];
  logic signed [ACC_W-1:0]   acc [4];
  logic [WS_W-1:0]           wsum;
  logic [1:0]                ch;
  logic                      neg;
  logic [ACC_W-1:0]          quo;
  logic [WS_W-1:0]           rem;
  logic [CNT_W-1:0]          cnt;
  logic [4*CHANNEL_BITS-1:0] res;
  logic                      res_zero;

  logic [ROW_W:0]    y_ext;
  logic [ROW_W:0]    y_plus_r;
  logic [SLOT_W-1:0] row_gap;
  logic [SLOT_W:0]   slot_wide;
  logic [SLOT_W-1:0] rd_slot;
  logic [ROW_W:0]    widx_wide;
  logic [WS_W:0]     trial;
  logic [ACC_W-1:0]  quo_signed;

  assign idle  = (state == B_IDLE);
  assign q_pop = idle && !q_stat.empty;

  assign y_ext    = {1'b0, jb.y};
  assign y_plus_r = y_ext + (ROW_W+1)'(jb.r);

  always_comb begin
    row_gap = SLOT_W'(jb.bottom - ny[ROW_W-1:0]);
    if (jb.bottom_slot >= row_gap) begin
      slot_wide = {1'b0, jb.bottom_slot} - {1'b0, row_gap};
    end else begin
      slot_wide = {1'b0, jb.bottom_slot} + (SLOT_W+1)'(DEPTH) - {1'b0, row_gap};
    end
    rd_slot   = slot_wide[SLOT_W-1:0];
    widx_wide = ny + (ROW_W+1)'(jb.r) - y_ext;
    trial     = {rem, quo[ACC_W-1]};
    quo_signed = neg ? (~quo + 1'b1) : quo;
  end

  always_ff @(posedge clk) begin
    if (wr.wgt_we) wmem[wr.wgt_idx[AW-1:0]] <= wr.wgt_val;
    if (wr.pix_we) pmem[wr.pix_slot[AW-1:0]] <= wr_pixel;
    if (state == B_RD) begin
      w_q <= wmem[widx_wide[AW-1:0]];
      p_q <= pmem[rd_slot[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        B_IDLE:  if (!q_stat.empty) state <= B_SETUP;
        B_SETUP: state <= B_RD;
        B_RD:    state <= (ny > hi) ? B_DINIT : B_MUL;
        B_MUL:   state <= B_ACC;
        B_ACC:   state <= B_RD;
        B_DINIT: state <= (wsum == '0) ? B_OUT : B_DLOAD;
        B_DLOAD: state <= B_DSTEP;
        B_DSTEP: if (cnt == CNT_W'(ACC_W - 1)) state <= B_DFIN;
        B_DFIN:  state <= (ch == 2'd3) ? B_OUT : B_DLOAD;
        B_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (!q_stat.empty) jb <= q_job;
      end
      B_SETUP: begin
        ny   <= (jb.y > ROW_W'(jb.r)) ? y_ext - (ROW_W+1)'(jb.r) : '0;
        hi   <= (y_plus_r < {1'b0, jb.bottom}) ? y_plus_r : {1'b0, jb.bottom};
        wsum <= '0;
        for (int c = 0; c < 4; c++) acc[c] <= '0;
      end
      B_MUL: begin
        for (int c = 0; c < 4; c++) begin
          prod[c] <= $signed({1'b0, w_q}) *
                     $signed(p_q[c*CHANNEL_BITS +: CHANNEL_BITS]);
        end
      end
      B_ACC: begin
        for (int c = 0; c < 4; c++) acc[c] <= acc[c] + ACC_W'(prod[c]);
        wsum <= wsum + WS_W'(w_q);
        ny   <= ny + (ROW_W+1)'(jb.s);
      end
      B_DINIT: begin
        ch       <= 2'd0;
        res_zero <= (wsum == '0);
        if (wsum == '0) res <= '0;
      end
      B_DLOAD: begin
        neg <= acc[ch][ACC_W-1];
        quo <= acc[ch][ACC_W-1] ? ACC_W'(-acc[ch]) : ACC_W'(acc[ch]);
        rem <= '0;
        cnt <= '0;
      end
      B_DSTEP: begin
        if (trial >= {1'b0, wsum}) begin
          rem <= WS_W'(trial - {1'b0, wsum});
          quo <= {quo[ACC_W-2:0], 1'b1};
        end else begin
          rem <= trial[WS_W-1:0];
          quo <= {quo[ACC_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
      end
      B_DFIN: begin
        res[ch*CHANNEL_BITS +: CHANNEL_BITS] <= quo_signed[CHANNEL_BITS-1:0];
        ch <= ch + 1'b1;
      end
      B_OUT: begin
        if (!out_valid || out_ready) begin
          out_pixel <= res;
          out_zero  <= res_zero;
          out_last  <= jb.last;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ design/vertical_normalized_blur.sv @@
// Path: a row's job goes through the job queue, then the back's setup, tap walk
//   (read, multiply, accumulate per tap), divider (load, steps, finish per channel)
//   and output register, after the pixel that completes its window.
// Input: no word is taken while a row job is queued or in the back, nor in a flush.
//   Weight loads and pixels that emit nothing are taken every cycle while the back is idle and the queue is empty.
// Reset: synchronous; radius 0, tap_stride 1, row counter 0, no output.
// ----------------------------------------------------------------------------
// vertical_normalized_blur
// Vertical blur over one column with edge renormalization.
// ----------------------------------------------------------------------------
module vertical_normalized_blur #(
  parameter int MAX_RADIUS   = vnb_pkg::MAX_RADIUS_DEF,
  parameter int CHANNEL_BITS = vnb_pkg::CHANNEL_BITS_DEF,
  parameter int IN_W  = ((23 + 4 * CHANNEL_BITS + 7) / 8) * 8,
  parameter int OUT_W = ((4 * CHANNEL_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // weight_index, weight_value, red_in, green_in, blue_in, alpha_in
  input  logic [IN_W-1:0]                   s_axis_tdata,
  input  logic                              s_axis_tlast,   // column_end
  input  logic                              s_axis_tuser,   // opcode
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // red_out, green_out, blue_out, alpha_out
  output logic [OUT_W-1:0]                  m_axis_tdata,
  output logic                              m_axis_tlast,   // flush_last
  output logic                              m_axis_tuser,   // zero_weight
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vnb_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [vnb_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [vnb_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import vnb_pkg::*;

  logic [RAD_W-1:0]          radius;
  logic [STR_W-1:0]          tap_stride;
  q_stat_t                   q_stat;
  logic                      back_idle;
  logic                      job_push;
  job_t                      job_in;
  job_t                      job_out;
  logic                      q_pop;
  mem_wr_t                   wr;
  logic [4*CHANNEL_BITS-1:0] wr_pixel;
  logic [4*CHANNEL_BITS-1:0] out_pixel;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius     <= '0;
      tap_stride <= STR_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_RADIUS: radius     <= pwdata[RAD_W-1:0];
        REG_STRIDE: tap_stride <= pwdata[STR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RADIUS: prdata = CFG_DATA_W'(radius);
      REG_STRIDE: prdata = CFG_DATA_W'(tap_stride);
      default:    prdata = '0;
    endcase
  end

  vnb_front #(.MAX_RADIUS(MAX_RADIUS), .CHANNEL_BITS(CHANNEL_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .opcode       (s_axis_tuser),
    .weight_index (s_axis_tdata[6:0]),
    .weight_value (s_axis_tdata[22:7]),
    .pixel        (s_axis_tdata[23 +: 4*CHANNEL_BITS]),
    .column_end   (s_axis_tlast),
    .radius       (radius),
    .tap_stride   (tap_stride),
    .q_stat       (q_stat),
    .back_idle    (back_idle),
    .job_push     (job_push),
    .job          (job_in),
    .wr           (wr),
    .wr_pixel     (wr_pixel)
  );

  vnb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job_in),
    .pop      (q_pop),
    .pop_job  (job_out),
    .stat     (q_stat)
  );

  vnb_back #(.MAX_RADIUS(MAX_RADIUS), .CHANNEL_BITS(CHANNEL_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .wr_pixel  (wr_pixel),
    .q_stat    (q_stat),
    .q_job     (job_out),
    .q_pop     (q_pop),
    .idle      (back_idle),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_pixel (out_pixel),
    .out_zero  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'(out_pixel);

endmodule

@@ design/vnb_checker.sv @@
// ----------------------------------------------------------------------------
// vnb_checker
// Port-level checks for the vertical normalized blur.
// ----------------------------------------------------------------------------
module vnb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // a pixel with column end always starts a flush, so input is blocked next cycle
  a_flush_block: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken during column flush");

  // a radius write reads back once registered
  a_radius_rb: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[2] == 1'b0 |=>
      (paddr[2] != 1'b0 || prdata[5:0] == $past(pwdata[5:0])))
    else $error("radius readback mismatch");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind vertical_normalized_blur vnb_checker u_vnb_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

@@ tb/vertical_normalized_blur_test.sv @@
// ----------------------------------------------------------------------------
// vertical_normalized_blur_test
// Checks the column blur against a cycle-free predictor: weight loads, pixel
// pushes, edge renormalization, stride, zero weight sums and column flushes,
// under random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module vertical_normalized_blur_test;
  import vnb_pkg::*;

  localparam int CB    = 24;
  localparam int MAXR  = 32;
  localparam int DEPTH = 2 * MAXR + 1;
  localparam int IN_W  = ((23 + 4 * CB + 7) / 8) * 8;
  localparam int OUT_W = ((4 * CB + 7) / 8) * 8;
  localparam logic [CFG_ADDR_W-1:0] ADDR_RADIUS = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_STRIDE = 3'd4;
  localparam longint CYCLE_LIMIT = 64'd3000000;
  localparam int HOLD_LEN = 2000;

  typedef struct packed {
    logic signed [CB-1:0] red;
    logic signed [CB-1:0] green;
    logic signed [CB-1:0] blue;
    logic signed [CB-1:0] alpha;
    logic                 zero_wt;
    logic                 last_row;
  } blur_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic m_axis_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  vertical_normalized_blur u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [15:0]          wtab [DEPTH];
  logic signed [CB-1:0] pix [DEPTH][4];
  logic [15:0]          rows_in_col;
  logic [5:0]           cfg_radius;
  logic [5:0]           cfg_stride;

  blur_row_t expected_rows[$];
  int errors = 0;
  int rows_seen = 0;
  int rows_acked = 0;
  int wait_left = 0;
  int pixels_sent = 0;
  int loads_sent = 0;
  int columns_done = 0;
  longint cycles = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_cycles = 0;
  bit rx_stall_on = 1'b1;
  bit tx_gap_on = 1'b1;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows pending", cycles, expected_rows.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic blur_row_t blur_row(int y, int bottom, int r, int s, bit last);
    longint acc[4];
    longint wsum;
    longint w;
    blur_row_t res;
    int lo, hi, ny, idx, slot;
    longint q;
    acc = '{0, 0, 0, 0};
    wsum = 0;
    lo = (y > r) ? y - r : 0;
    hi = (y + r < bottom) ? y + r : bottom;
    for (ny = lo; ny <= hi; ny += s) begin
      idx = ny + r - y;
      slot = ny % DEPTH;
      if (idx < DEPTH) begin
        w = wtab[idx];
        for (int c = 0; c < 4; c++) acc[c] += w * longint'(pix[slot][c]);
        wsum += w;
      end
    end
    q = (wsum != 0) ? acc[0] / wsum : 0; res.red = q[CB-1:0];
    q = (wsum != 0) ? acc[1] / wsum : 0; res.green = q[CB-1:0];
    q = (wsum != 0) ? acc[2] / wsum : 0; res.blue = q[CB-1:0];
    q = (wsum != 0) ? acc[3] / wsum : 0; res.alpha = q[CB-1:0];
    res.zero_wt = (wsum == 0);
    res.last_row = last;
    return res;
  endfunction

  task automatic predict_word(logic op, logic [6:0] widx, logic [15:0] wval,
                              logic signed [CB-1:0] ch[4], logic col_end);
    int n, r, s, y;
    if (op == OP_LOAD_WEIGHT) begin
      if (widx < DEPTH) wtab[widx] = wval;
      return;
    end
    n = rows_in_col;
    for (int c = 0; c < 4; c++) pix[n % DEPTH][c] = ch[c];
    r = (cfg_radius > MAXR) ? MAXR : cfg_radius;
    s = (cfg_stride == 0) ? 1 : cfg_stride;
    if (col_end) begin
      for (y = (n >= r) ? n - r : 0; y <= n; y++)
        expected_rows.push_back(blur_row(y, n, r, s, y == n));
      rows_in_col = 0;
    end else begin
      if (n >= r) expected_rows.push_back(blur_row(n - r, n, r, s, 1'b0));
      rows_in_col = 16'(n + 1);
    end
  endtask

  // sends one word; gap drawn per word
  task automatic send_word(logic op, logic [6:0] widx, logic [15:0] wval,
                           logic signed [CB-1:0] ch[4], logic col_end);
    int gap;
    gap = tx_gap_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    predict_word(op, widx, wval, ch, col_end);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tlast <= col_end;
    s_axis_tdata <= {1'b0, ch[3], ch[2], ch[1], ch[0], wval, widx};
    do @(posedge clk); while (!s_axis_tready);
    if (op == OP_LOAD_WEIGHT) loads_sent++; else pixels_sent++;
  endtask

  task automatic load_weight(int idx, int val);
    logic signed [CB-1:0] ch[4];
    for (int c = 0; c < 4; c++) ch[c] = CB'($urandom());
    send_word(OP_LOAD_WEIGHT, idx[6:0], val[15:0], ch, 1'($urandom_range(0, 1)));
  endtask

  task automatic push_pixel(logic signed [CB-1:0] ch[4], bit col_end);
    send_word(OP_PUSH_PIXEL, 7'($urandom()), 16'($urandom()), ch, col_end);
    if (col_end) columns_done++;
  endtask

  task automatic push_random_column(int len);
    logic signed [CB-1:0] ch[4];
    for (int i = 0; i < len; i++) begin
      for (int c = 0; c < 4; c++) ch[c] = CB'($urandom());
      push_pixel(ch, i == len - 1);
    end
  endtask

  task automatic drain;
    int t;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    t = 0;
    while (expected_rows.size() > 0 && t < 500000) begin
      @(posedge clk);
      t++;
    end
    repeat (4 * 65 + 4 * 48 + 50) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_RADIUS) cfg_radius = val[5:0];
    else cfg_stride = val[5:0];
  endtask

  task automatic set_filter(int r, int s);
    drain();
    write_reg(ADDR_RADIUS, r);
    write_reg(ADDR_STRIDE, s);
  endtask

  // table covers every index the current radius can read
  task automatic fill_weights(int r, bit allow_zero);
    for (int i = 0; i <= 2 * ((r > MAXR) ? MAXR : r); i++)
      load_weight(i, (allow_zero && $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535));
  endtask

  // checker
  always @(posedge clk) begin
    blur_row_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.red = m_axis_tdata[CB-1:0];
      got.green = m_axis_tdata[2*CB-1:CB];
      got.blue = m_axis_tdata[3*CB-1:2*CB];
      got.alpha = m_axis_tdata[4*CB-1:3*CB];
      got.zero_wt = m_axis_tuser;
      got.last_row = m_axis_tlast;
      rows_seen++;
      if (expected_rows.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected row %p", got);
      end else begin
        want = expected_rows.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("row %0d mismatch: expected %p got %p", rows_seen, want, got);
        end
      end
    end
  end

  // receiver: a wait drawn after each taken word, plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_cycles = hold_cycles + 1;
      if (hold_cycles >= HOLD_LEN) hold_done = 1'b1;
    end else begin
      if (rows_seen != rows_acked) begin
        rows_acked = rows_seen;
        wait_left = rx_stall_on ? $urandom_range(0, 13) : 0;
      end
      if (wait_left > 0) begin
        m_axis_tready <= 1'b0;
        wait_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic test_directed;
    logic signed [CB-1:0] ch[4];
    // radius 0, single tap weight zero then nonzero
    set_filter(0, 1);
    load_weight(0, 0);
    ch = '{24'sh7FFFFF, -24'sh800000, 24'sh000001, -24'sh1};
    push_pixel(ch, 1'b1);
    load_weight(0, 65535);
    load_weight(100, 5);   // ignored index
    load_weight(127, 5);
    push_pixel(ch, 1'b0);
    ch = '{-24'sh800000, 24'sh7FFFFF, 24'sh0, 24'sh123456};
    push_pixel(ch, 1'b1);
    // radius 2: short column and edge renormalization
    set_filter(2, 1);
    load_weight(0, 1); load_weight(1, 3); load_weight(2, 65535);
    load_weight(3, 3); load_weight(4, 1);
    push_random_column(1);
    push_random_column(2);
    push_random_column(6);
    // max radius with stride
    set_filter(MAXR, 32);
    fill_weights(MAXR, 1'b0);
    load_weight(64, 65535);
    push_random_column(3);
  endtask

  task automatic test_random_settings;
    int r, s;
    for (int k = 0; k < 10; k++) begin
      r = (k == 0) ? 63 : (k == 1) ? 0 : $urandom_range(0, 8);
      s = (k == 2) ? 0 : (k == 3) ? 63 : $urandom_range(1, 4);
      set_filter(r, s);
      fill_weights(r, k % 3 == 0);
      for (int j = 0; j < 2; j++) push_random_column($urandom_range(1, 9));
    end
  endtask

  // output held off while a long column keeps coming, then free-running output
  task automatic test_backpressure;
    set_filter(3, 2);
    fill_weights(3, 1'b0);
    hold_req = 1'b1;
    tx_gap_on = 1'b0;
    push_random_column(20);
    hold_req = 1'b0;
    tx_gap_on = 1'b1;
    rx_stall_on = 1'b0;
    push_random_column(8);
    rx_stall_on = 1'b1;
  endtask

  initial begin
    rows_in_col = 0;
    cfg_radius = 0;
    cfg_stride = 1;
    for (int i = 0; i < DEPTH; i++) wtab[i] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_settings();
    test_backpressure();
    drain();
    $display("sent %0d pixels in %0d columns and %0d weight loads; checked %0d rows",
             pixels_sent, columns_done, loads_sent, rows_seen);
    $display("radius 0..63, stride 0..63, long output hold-off of %0d cycles", hold_cycles);
    if (errors == 0 && expected_rows.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d rows missing", errors, expected_rows.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
